>>> design/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Holds the configured pattern, the register index codes and the field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	// Width and depth of the configured pattern store. These are set by the
	// register layout and do not vary.
	localparam int unsigned PAT_BYTES = 16;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 64;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register index codes.
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd3;

	typedef logic [7:0] data_t;

	// Pattern settings that every cell of the window sees.
	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pat;
		logic [PAT_BYTES-1:0]      care;
		logic [LEN_W-1:0]          len;
	} pat_cfg_t;

endpackage

`default_nettype wire

>>> design/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell: one byte of the scan window
// Holds one window byte, passes it to the next cell on every accepted item and
// compares it against the pattern byte that lines up with its position.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell #(
	parameter int unsigned POS = 0
) (
	input  wire               clk,
	input  wbps_pkg::pat_cfg_t cfg,
	input  wire               shift_en,
	input  wbps_pkg::data_t   din,
	output wbps_pkg::data_t   dout,
	output logic              hit
);
	import wbps_pkg::*;

	data_t            byte_q;
	logic [LEN_W-1:0] pat_idx;
	logic             in_range;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// Window entry 0 is the newest byte, so the oldest byte of the match
	// meets pattern byte 0.
	assign in_range = cfg.len > LEN_W'(POS);
	assign pat_idx  = cfg.len - LEN_W'(POS) - LEN_W'(1);

	always_comb begin
		hit = 1'b1;
		if (in_range && cfg.care[pat_idx[3:0]]) begin
			hit = (byte_q == cfg.pat[pat_idx[3:0]]);
		end
	end

endmodule

`default_nettype wire

>>> design/wildcard_byte_pattern_scanner_top.sv
// Pipeline: the edge that accepts an item loads the compare stage, and its result, if there
//   is one, then moves on into the output register once the output is free.
// Throughput: one item per cycle while the input is not stalled; the window cells shift and compare in parallel.
// The input stalls only while a result waits in the compare stage behind a stalled output.
// Reset clears the byte counter, the reported flag, the pipeline valids and the
//   configuration registers; the window bytes are not cleared.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top: wildcard byte pattern scanner
// Shifts the byte stream through a row of window cells, compares the window
// with a masked pattern and reports the first match or a not-found per region.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_top #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire  [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [wbps_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [7:0]                           data_byte,
	input  wire                                  last_byte,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 found,
	output logic [31:0]                          match_offset
);
	import wbps_pkg::*;

	// Configuration registers.
	logic [63:0]      pat_lo_q;
	logic [63:0]      pat_hi_q;
	logic [15:0]      care_q;
	logic [LEN_W-1:0] len_q;
	pat_cfg_t         cfg;

	// Scan state and pipeline.
	logic [CNT_W-1:0] bytes_seen_q;
	logic             reported_q;
	logic             valid_s1;
	logic             last_s1;
	logic             ovf_s1;
	logic             ge_s1;
	logic [CNT_W-1:0] count_s1;
	logic             out_valid_q;
	logic             found_q;
	logic [CNT_W-1:0] offset_q;

	logic                         accept;
	logic                         overflowed;
	logic [CNT_W-1:0]             count_next;
	logic                         len_ok;
	logic                         match_s1;
	logic                         result_s1;
	logic                         out_free;
	logic                         go_s1;
	logic [MAX_PATTERN_BYTES-1:0] hits;
	data_t                        chain [MAX_PATTERN_BYTES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PAT_LO:  pat_lo_q <= cfg_data;
				CFG_PAT_HI:  pat_hi_q <= cfg_data;
				CFG_CARE:    care_q   <= cfg_data[15:0];
				CFG_PAT_LEN: len_q    <= cfg_data[LEN_W-1:0];
				default:     ;
			endcase
		end
	end

	assign cfg.pat  = {pat_hi_q, pat_lo_q};
	assign cfg.care = care_q;
	assign cfg.len  = len_q;

	// Window: a row of cells, entry 0 newest.
	assign chain[0] = data_byte;

	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		wbps_cell #(
			.POS(k)
		) u_cell (
			.clk      (clk),
			.cfg      (cfg),
			.shift_en (accept),
			.din      (chain[k]),
			.dout     (chain[k+1]),
			.hit      (hits[k])
		);
	end

	// Handshake. The window only shifts when the compare stage is empty or
	// moving on, so the compare always sees the window of its own item.
	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && (!result_s1 || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign accept   = in_valid && !in_stall;

	// Byte counter, saturating.
	assign overflowed = (bytes_seen_q == CNT_MAX);
	assign count_next = overflowed ? bytes_seen_q : bytes_seen_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
		end else if (accept) begin
			bytes_seen_q <= last_byte ? '0 : count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= last_byte;
			ovf_s1   <= overflowed;
			count_s1 <= count_next;
			ge_s1    <= count_next >= CNT_W'(len_q);
		end
	end

	// Compare stage.
	assign len_ok    = (len_q != '0) && ({1'b0, len_q} <= (LEN_W+1)'(MAX_PATTERN_BYTES));
	assign match_s1  = !reported_q && !ovf_s1 && len_ok && ge_s1 && (&hits);
	assign result_s1 = match_s1 || (last_s1 && !reported_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				reported_q <= 1'b0;
			end else if (match_s1) begin
				reported_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && result_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && result_s1) begin
			found_q  <= match_s1;
			offset_q <= match_s1 ? count_s1 - CNT_W'(len_q) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule

`default_nettype wire

>>> design/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker: port-level checks of the wildcard byte pattern scanner
// Watches the handshake and the result fields at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        found,
	input wire [31:0] match_offset
);

	// A stalled result item holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_offset))
		else $error("result item changed while stalled");

	// A not-found result always carries a zero offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == 32'd0)
		else $error("not-found result with non-zero offset");

	// The input only stalls when a result is held up at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// Once a stalled result leaves, the input is free again in that cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.found        (found),
	.match_offset (match_offset)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the wildcard byte pattern scanner
// Streams byte regions through the scanner under random sender gaps and
// receiver stalls, predicts the found/not-found report of each region and
// checks every report field by field in order.
// ----------------------------------------------------------------------------

module tb;

	localparam int          MAX_PAT       = 16;
	localparam int unsigned RANDOM_ITEMS  = 1250;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_SHOWN     = 10;

	typedef struct packed {
		logic        found;
		logic [31:0] offset;
	} scan_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wbps_pkg::CFG_DAT_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	wbps_pkg::data_t data_byte;
	logic last_byte;
	logic out_valid;
	logic out_stall;
	logic found;
	logic [31:0] match_offset;

	// Scanner state as the testbench sees it.
	wbps_pkg::pat_cfg_t scan_cfg = '0;
	wbps_pkg::data_t recent_bytes [MAX_PAT];
	logic [wbps_pkg::CNT_W-1:0] bytes_seen = '0;
	logic reported = 1'b0;

	scan_report_t pending_reports [$];
	scan_report_t want;
	wbps_pkg::data_t region_bytes [$];

	int unsigned mismatches  = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	logic [31:0] cycle_count = '0;

	wildcard_byte_pattern_scanner_top #(
		.MAX_PATTERN_BYTES(MAX_PAT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.match_offset(match_offset)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** wildcard_byte_pattern_scanner_top: FAILED **");
			$finish;
		end
	end

	// The receiver's stall habit is picked by bits 9:7 of the cycle counter.
	always @(posedge clk) begin
		case (cycle_count[9:7])
			3'd0, 3'd1: out_stall <= 1'b0;
			3'd2: out_stall <= ($urandom_range(0, 1) == 0);
			3'd3: out_stall <= (cycle_count[1:0] == 2'd0);
			3'd4: out_stall <= (cycle_count[4:0] < 5'd12);
			3'd5: out_stall <= ($urandom_range(0, 7) == 0);
			default: out_stall <= ($urandom_range(0, 2) != 0);
		endcase
	end

	function automatic void scan_byte(input wbps_pkg::data_t b, input logic last);
		logic saturated;
		logic hit;
		int unsigned plen;
		int k;
		int j;
		scan_report_t r;
		saturated = (bytes_seen == wbps_pkg::CNT_MAX);
		for (k = MAX_PAT - 1; k > 0; k--)
			recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = b;
		if (!saturated)
			bytes_seen = bytes_seen + 1'b1;
		plen = scan_cfg.len;
		hit = !reported && !saturated && plen != 0 && plen <= MAX_PAT && bytes_seen >= plen;
		// Pattern byte 0 lines up with the oldest byte of the compared window.
		for (j = 0; j < plen && hit; j++)
			if (scan_cfg.care[j] && recent_bytes[plen - 1 - j] != scan_cfg.pat[j])
				hit = 1'b0;
		if (hit) begin
			r.found = 1'b1;
			r.offset = bytes_seen - plen;
			reported = 1'b1;
			pending_reports = {pending_reports, r};
		end else if (last && !reported) begin
			r = '0;
			pending_reports = {pending_reports, r};
		end
		if (last) begin
			bytes_seen = '0;
			reported = 1'b0;
			for (k = 0; k < MAX_PAT; k++)
				recent_bytes[k] = '0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			scan_byte(data_byte, last_byte);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				if (mismatches < MAX_SHOWN)
					$display("unexpected report: found=%0d offset=%0d", found, match_offset);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (found !== want.found || match_offset !== want.offset) begin
					if (mismatches < MAX_SHOWN)
						$display("report mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
							want.found, want.offset, found, match_offset);
					mismatches++;
				end
			end
		end
	end

	task automatic send_byte(input wbps_pkg::data_t b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Waits until every expected report has come out and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [wbps_pkg::CFG_DAT_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			wbps_pkg::CFG_PAT_LO: scan_cfg.pat[7:0] = value;
			wbps_pkg::CFG_PAT_HI: scan_cfg.pat[15:8] = value;
			wbps_pkg::CFG_CARE: scan_cfg.care = value[15:0];
			wbps_pkg::CFG_PAT_LEN: scan_cfg.len = value[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] care_word, input logic [63:0] len_word);
		write_reg(wbps_pkg::CFG_PAT_LO, lo);
		write_reg(wbps_pkg::CFG_PAT_HI, hi);
		write_reg(wbps_pkg::CFG_CARE, care_word);
		write_reg(wbps_pkg::CFG_PAT_LEN, len_word);
	endtask

	// After reset the pattern length is zero, so a region can only end unmatched.
	task automatic test_zero_length();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
	endtask

	task automatic test_full_width_pattern();
		int j;
		configure(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 64'hFFFF, 64'd16);
		for (j = 0; j < MAX_PAT; j++)
			send_byte(scan_cfg.pat[j], j == MAX_PAT - 1);
		settle();
	endtask

	// With every position a wildcard, each byte matches; only the first counts.
	task automatic test_first_match_only();
		configure(64'h0, 64'h0, 64'h0, 64'd1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
	endtask

	task automatic test_length_over_max();
		configure(64'h0, 64'h0, 64'h0, 64'd17);
		send_byte(8'hA5, 1'b1);
		settle();
		write_reg(wbps_pkg::CFG_PAT_LEN, 64'd31);
		send_byte(8'h5A, 1'b1);
		settle();
	endtask

	task automatic test_short_region();
		configure(64'hEF_CD_AB, 64'h0, 64'h7, 64'd3);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b1);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b0);
		send_byte(8'hEF, 1'b1);
		settle();
	endtask

	// The pattern changes while a region is open; the next byte sees the new one.
	task automatic test_config_mid_region();
		configure(64'h22_11, 64'h0, 64'h3, 64'd2);
		send_byte(8'h11, 1'b0);
		settle();
		write_reg(wbps_pkg::CFG_PAT_LO, 64'h44_11);
		send_byte(8'h44, 1'b1);
		settle();
	endtask

	task automatic pick_config();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] care_word;
		logic [63:0] len_word;
		int unsigned pick;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			lo = '1;
			hi = '1;
		end else if (pick == 1) begin
			lo = '0;
			hi = '0;
		end
		care_word = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0)
			care_word[15:0] = '1;
		else if (pick == 1)
			care_word[15:0] = '0;
		else if (pick < 5)
			care_word[15:0] = '1 ^ (16'h1 << $urandom_range(0, 15));
		len_word = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 13)
			len_word[4:0] = $urandom_range(1, 6);
		else if (pick < 15)
			len_word[4:0] = $urandom_range(7, 15);
		else if (pick < 17)
			len_word[4:0] = 5'd16;
		else if (pick == 17)
			len_word[4:0] = 5'd0;
		else
			len_word[4:0] = $urandom_range(17, 31);
		// Not every phase rewrites every register.
		if ($urandom_range(0, 3) != 0)
			write_reg(wbps_pkg::CFG_PAT_LO, lo);
		if ($urandom_range(0, 3) != 0)
			write_reg(wbps_pkg::CFG_PAT_HI, hi);
		if ($urandom_range(0, 3) != 0)
			write_reg(wbps_pkg::CFG_CARE, care_word);
		if ($urandom_range(0, 3) != 0)
			write_reg(wbps_pkg::CFG_PAT_LEN, len_word);
	endtask

	// Most regions are built from pattern bytes and often carry a planted copy
	// of the pattern, so that partial and overlapping matches are common.
	task automatic build_region();
		int unsigned size;
		int unsigned plen;
		int unsigned style;
		int unsigned at;
		int unsigned j;
		wbps_pkg::data_t b;
		region_bytes.delete();
		plen = scan_cfg.len;
		style = $urandom_range(0, 9);
		if ($urandom_range(0, 11) == 0)
			size = $urandom_range(40, 220);
		else if (plen >= 2 && plen <= MAX_PAT && $urandom_range(0, 7) == 0)
			size = plen - 1;
		else
			size = $urandom_range(1, 24);
		for (j = 0; j < size; j++) begin
			b = $urandom_range(0, 255);
			if (style >= 3 && plen != 0 && plen <= MAX_PAT && $urandom_range(0, 3) != 0)
				b = scan_cfg.pat[$urandom_range(0, plen - 1)];
			region_bytes = {region_bytes, b};
		end
		if (style >= 3 && plen != 0 && plen <= MAX_PAT && size >= plen
				&& $urandom_range(0, 3) != 0) begin
			at = $urandom_range(0, size - plen);
			for (j = 0; j < plen; j++)
				if (scan_cfg.care[j])
					region_bytes[at + j] = scan_cfg.pat[j];
		end
	endtask

	task automatic test_random_scans();
		wbps_pkg::data_t carry [$];
		int unsigned stop_at;
		int unsigned target;
		int unsigned split;
		int k;
		stop_at = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < stop_at) begin
			settle();
			pick_config();
			// Finish the region that the previous phase left open.
			for (k = 0; k < carry.size(); k++)
				send_byte(carry[k], k == carry.size() - 1);
			carry.delete();
			target = bytes_sent + $urandom_range(20, 120);
			while (bytes_sent < target) begin
				build_region();
				split = region_bytes.size();
				if (bytes_sent + split >= target && split > 1 && $urandom_range(0, 3) == 0)
					split = $urandom_range(1, split - 1);
				for (k = 0; k < region_bytes.size(); k++)
					if (k < split)
						send_byte(region_bytes[k], k == region_bytes.size() - 1);
					else
						carry = {carry, region_bytes[k]};
			end
		end
		for (k = 0; k < carry.size(); k++)
			send_byte(carry[k], k == carry.size() - 1);
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		out_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_length();
		test_full_width_pattern();
		test_first_match_only();
		test_length_over_max();
		test_short_region();
		test_config_mid_region();
		test_random_scans();
		if (mismatches == 0)
			$display("** wildcard_byte_pattern_scanner_top: PASSED **");
		else
			$display("** wildcard_byte_pattern_scanner_top: FAILED **");
		$finish;
	end

endmodule
